// ===== design/grid_astar_path_search_top_macros.svh =====
// Assertion macros shared by the grid A* search modules.
// Each macro expects clk and rst_n in scope.
`ifndef GRID_ASTAR_PATH_SEARCH_TOP_MACROS_SVH
`define GRID_ASTAR_PATH_SEARCH_TOP_MACROS_SVH
// Condition that holds at every clock edge outside reset.
`define GAPS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Consequence that holds in the cycle after the antecedent.
`define GAPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ===== design/gaps_pkg.sv =====
// Package for the grid A* search engine: sizes, codes, cell record, state and op types.
// No dependencies; used by every module of the block.
`default_nettype none

package gaps_pkg;

    localparam int GRID_W = 64;
    localparam int GRID_H = 64;
    localparam int NCELLS = GRID_W * GRID_H;
    localparam int XW     = $clog2(GRID_W);
    localparam int YW     = $clog2(GRID_H);
    localparam int CW     = XW + YW;
    localparam int NW     = CW + 1;

    localparam logic [15:0] STEP_STRAIGHT = 16'd10;
    localparam logic [15:0] STEP_DIAG     = 16'd14;
    localparam logic [15:0] G_MAX         = 16'hFFFF;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    localparam logic [2:0] CFG_HMODE  = 3'd0;
    localparam logic [2:0] CFG_DIAG   = 3'd1;
    localparam logic [2:0] CFG_WIDTH  = 3'd2;
    localparam logic [2:0] CFG_HEIGHT = 3'd3;

    localparam logic [1:0] HMODE_EUCLID = 2'd1;
    localparam logic [1:0] HMODE_OCT    = 2'd2;

    // Root of a value below 2^20 takes ten digit steps.
    localparam int SQ_STEPS = 10;

    typedef struct packed {
        logic [15:0] g;
        logic [15:0] h;
        logic [2:0]  pdir;
        logic        parent;
        logic        open;
        logic        closed;
        logic        path;
    } mark_t;

    typedef enum logic [4:0] {
        ST_INIT, ST_IDLE, ST_DISPATCH, ST_WRITE, ST_NULL, ST_RD_ISSUE, ST_RD_TAKE,
        ST_CLR, ST_START, ST_SEL, ST_SCAN_A, ST_SCAN_B, ST_PICK, ST_SHIFT, ST_CLOSE,
        ST_NB, ST_NB_EVAL, ST_H_WAIT, ST_PATH, ST_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_NOP, OP_CLR_ALL, OP_LATCH, OP_WALL_WR, OP_FAIL_RES, OP_RD_ISSUE, OP_RD_TAKE,
        OP_CLR_MARK, OP_START, OP_SCAN_INIT, OP_SCAN_A, OP_SCAN_B, OP_PICK, OP_SHIFT,
        OP_CLOSE, OP_NB, OP_NB_EVAL, OP_H_WAIT, OP_PATH_INIT, OP_PATH, OP_PUSH
    } op_t;

    typedef struct packed {
        op_t op;
    } ctrl_t;

    typedef struct packed {
        logic       clr_last;
        logic [1:0] cmd;
        logic       off_grid;
        logic       cnt_zero;
        logic       scan_last;
        logic       pick_goal;
        logic       pick_more;
        logic       shift_more;
        logic       nb_end;
        logic       nb_inb;
        logic       need_sqrt;
        logic       sq_done;
        logic       path_stop;
        logic       slot_free;
    } status_t;

    function automatic logic [7:0] dir_dx(input logic [2:0] d);
        logic [7:0] r;
        case (d)
            3'd1, 3'd5, 3'd7: r = 8'h01;
            3'd3, 3'd4, 3'd6: r = 8'hFF;
            default:          r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] dir_dy(input logic [2:0] d);
        logic [7:0] r;
        case (d)
            3'd0, 3'd5, 3'd6: r = 8'h01;
            3'd2, 3'd4, 3'd7: r = 8'hFF;
            default:          r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] back_dir(input logic [2:0] d);
        logic [2:0] r;
        case (d)
            3'd0:    r = 3'd2;
            3'd1:    r = 3'd3;
            3'd2:    r = 3'd0;
            3'd3:    r = 3'd1;
            3'd4:    r = 3'd5;
            3'd5:    r = 3'd4;
            3'd6:    r = 3'd7;
            default: r = 3'd6;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/gaps_sqrt.sv =====
// Euclidean estimate unit: floor(10*sqrt(dx^2+dy^2)) by digit-by-digit square root.
// Depends on gaps_pkg.
`default_nettype none

module gaps_sqrt (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [5:0] dx,
    input  wire logic [5:0] dy,
    output logic            done,
    output logic [9:0]      root
);

    logic [3:0]  stage_reg, stage_next;
    logic        done_reg;
    logic [12:0] sq_reg;
    logic [19:0] v_reg, r_reg, b_reg;
    logic [19:0] rb;
    logic [19:0] sq_ext;

    assign rb     = r_reg + b_reg;
    assign sq_ext = {7'd0, sq_reg};

    // The start cycle squares, stage 1 scales by 100, stages 2 onward take one root digit each.
    always_comb
    begin
        stage_next = stage_reg;
        if (start)
        begin
            stage_next = 4'd1;
        end
        else if (stage_reg == 4'(gaps_pkg::SQ_STEPS + 1))
        begin
            stage_next = 4'd0;
        end
        else if (stage_reg != 4'd0)
        begin
            stage_next = stage_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= 4'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= stage_next;
            done_reg  <= (stage_reg == 4'(gaps_pkg::SQ_STEPS + 1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sq_reg <= 13'({7'd0, dx} * {7'd0, dx}) + 13'({7'd0, dy} * {7'd0, dy});
        end
        else if (stage_reg == 4'd1)
        begin
            v_reg <= (sq_ext << 6) + (sq_ext << 5) + (sq_ext << 2);
            r_reg <= 20'd0;
            b_reg <= 20'd1 << 18;
        end
        else if (stage_reg != 4'd0)
        begin
            if (v_reg >= rb)
            begin
                v_reg <= v_reg - rb;
                r_reg <= (r_reg >> 1) + b_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            b_reg <= b_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = r_reg[9:0];

endmodule

`default_nettype wire

// ===== design/gaps_datapath.sv =====
// Datapath of the grid A* engine: cell, wall and open-list memories, search registers,
// configuration and result registers. Depends on gaps_pkg, gaps_sqrt and the macro header.
`default_nettype none
`include "grid_astar_path_search_top_macros.svh"

module gaps_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire gaps_pkg::ctrl_t   ctrl,
    output gaps_pkg::status_t      status,
    input  wire logic [1:0]        cmd,
    input  wire logic [5:0]        cell_x,
    input  wire logic [5:0]        cell_y,
    input  wire logic              wall_bit,
    input  wire logic [5:0]        goal_x,
    input  wire logic [5:0]        goal_y,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output logic                   found,
    output logic [15:0]            cost,
    output logic                   is_wall,
    output logic                   on_path,
    output logic [2:0]             parent_dir,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [6:0]        cfg_data
);

    localparam int CW = gaps_pkg::CW;
    localparam int NW = gaps_pkg::NW;

    gaps_pkg::op_t op;
    assign op = ctrl.op;

    // Storage.
    logic            wall_mem [gaps_pkg::NCELLS];
    gaps_pkg::mark_t mark_mem [gaps_pkg::NCELLS];
    logic [CW-1:0]   ord_mem  [gaps_pkg::NCELLS];

    logic            wall_rd_reg;
    gaps_pkg::mark_t mark_rd_reg;
    logic [CW-1:0]   ord_rd_reg;

    // Configuration.
    logic [1:0] hmode_reg;
    logic       diag_reg;
    logic [6:0] gw_reg, gh_reg;

    // Latched request.
    logic [1:0] cmd_reg;
    logic [5:0] x_reg, y_reg, gx_reg, gy_reg;
    logic       wb_reg;

    // Search registers.
    logic [CW-1:0]   clr_reg;
    logic [NW-1:0]   cnt_reg;
    logic [CW-1:0]   k_reg;
    logic [CW-1:0]   cand_reg;
    logic [CW-1:0]   best_k_reg, best_cell_reg;
    logic [16:0]     best_f_reg;
    gaps_pkg::mark_t best_mark_reg;
    logic [3:0]      dir_reg;
    logic [CW-1:0]   nb_reg;
    logic [CW-1:0]   pc_reg;
    logic [CW-1:0]   steps_reg;

    // Result registers.
    logic        pend_found_reg, pend_wall_reg, pend_path_reg;
    logic [15:0] pend_cost_reg;
    logic [2:0]  pend_pdir_reg;
    logic        res_valid_reg;
    logic        out_found_reg, out_wall_reg, out_path_reg;
    logic [15:0] out_cost_reg;
    logic [2:0]  out_pdir_reg;

    // Derived values.
    logic [CW-1:0] start_cell, goal_cell;
    logic [7:0]    nx, ny, px, py;
    logic          nb_inb, path_off;
    logic [CW-1:0] nb_cell, par_cell;
    logic [16:0]   scan_f;
    logic [16:0]   tc_wide;
    logic [15:0]   tc;
    logic          nb_skip, nb_new, nb_better, need_sqrt, do_append;
    logic [5:0]    dxg, dyg, mng;
    logic [15:0]   sum_g, min_g, h_simple;
    logic          sq_done;
    logic [9:0]    sq_root;
    gaps_pkg::mark_t new_mark;
    logic [NW-1:0] k_p1, k_p2, bk_p1;

    assign start_cell = {y_reg, x_reg};
    assign goal_cell  = {gy_reg, gx_reg};

    assign nx = {2'b00, best_cell_reg[5:0]} + gaps_pkg::dir_dx(dir_reg[2:0]);
    assign ny = {2'b00, best_cell_reg[11:6]} + gaps_pkg::dir_dy(dir_reg[2:0]);
    assign nb_inb = (nx[7:6] == 2'b00) && (ny[7:6] == 2'b00)
                    && (nx < {1'b0, gw_reg}) && (ny < {1'b0, gh_reg});
    assign nb_cell = {ny[5:0], nx[5:0]};

    assign px = {2'b00, pc_reg[5:0]} + gaps_pkg::dir_dx(mark_rd_reg.pdir);
    assign py = {2'b00, pc_reg[11:6]} + gaps_pkg::dir_dy(mark_rd_reg.pdir);
    assign path_off = (px[7:6] != 2'b00) || (py[7:6] != 2'b00);
    assign par_cell = {py[5:0], px[5:0]};

    assign scan_f = {1'b0, mark_rd_reg.g} + {1'b0, mark_rd_reg.h};

    assign tc_wide = {1'b0, best_mark_reg.g}
                     + {1'b0, (dir_reg[2] ? gaps_pkg::STEP_DIAG : gaps_pkg::STEP_STRAIGHT)};
    assign tc = tc_wide[16] ? gaps_pkg::G_MAX : tc_wide[15:0];

    assign nb_skip   = wall_rd_reg || mark_rd_reg.closed;
    assign nb_new    = !nb_skip && !mark_rd_reg.open;
    assign nb_better = !nb_skip && mark_rd_reg.open && (tc < mark_rd_reg.g);
    assign need_sqrt = nb_new && (hmode_reg == gaps_pkg::HMODE_EUCLID);
    assign do_append = ((op == gaps_pkg::OP_NB_EVAL) && nb_new && !need_sqrt)
                       || ((op == gaps_pkg::OP_H_WAIT) && sq_done);

    // Distance from the neighbor to the goal.
    assign dxg = (nb_reg[5:0] > gx_reg) ? nb_reg[5:0] - gx_reg : gx_reg - nb_reg[5:0];
    assign dyg = (nb_reg[11:6] > gy_reg) ? nb_reg[11:6] - gy_reg : gy_reg - nb_reg[11:6];
    assign mng = (dxg < dyg) ? dxg : dyg;
    assign sum_g = {10'd0, dxg} + {10'd0, dyg};
    assign min_g = {10'd0, mng};
    assign h_simple = (hmode_reg == gaps_pkg::HMODE_OCT)
                      ? (sum_g << 3) + (sum_g << 1) - (min_g << 2) - (min_g << 1)
                      : (sum_g << 3) + (sum_g << 1);

    always_comb
    begin
        new_mark        = '0;
        new_mark.g      = tc;
        new_mark.h      = (hmode_reg == gaps_pkg::HMODE_EUCLID) ? {6'd0, sq_root} : h_simple;
        new_mark.pdir   = gaps_pkg::back_dir(dir_reg[2:0]);
        new_mark.parent = 1'b1;
        new_mark.open   = 1'b1;
    end

    assign k_p1  = {1'b0, k_reg} + NW'(1);
    assign k_p2  = {1'b0, k_reg} + NW'(2);
    assign bk_p1 = {1'b0, best_k_reg} + NW'(1);

    gaps_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start ((op == gaps_pkg::OP_NB_EVAL) && need_sqrt),
        .dx    (dxg),
        .dy    (dyg),
        .done  (sq_done),
        .root  (sq_root)
    );

    // Memory port selection.
    logic            mark_we, wall_we, ord_we;
    logic [CW-1:0]   mark_raddr, mark_waddr, wall_waddr, ord_raddr, ord_waddr;
    gaps_pkg::mark_t mark_wdata;
    logic            wall_wdata;
    logic [CW-1:0]   ord_wdata;

    always_comb
    begin
        mark_raddr = '0;
        ord_raddr  = '0;
        unique case (op)
            gaps_pkg::OP_RD_ISSUE:  mark_raddr = start_cell;
            gaps_pkg::OP_SCAN_A:    mark_raddr = ord_rd_reg;
            gaps_pkg::OP_NB:        mark_raddr = nb_cell;
            gaps_pkg::OP_PATH_INIT: mark_raddr = best_cell_reg;
            gaps_pkg::OP_PATH:      mark_raddr = par_cell;
            gaps_pkg::OP_SCAN_B:    ord_raddr  = k_p1[CW-1:0];
            gaps_pkg::OP_PICK:      ord_raddr  = bk_p1[CW-1:0];
            gaps_pkg::OP_SHIFT:     ord_raddr  = k_p2[CW-1:0];
            default:                mark_raddr = '0;
        endcase
    end

    always_comb
    begin
        mark_we    = 1'b0;
        mark_waddr = nb_reg;
        mark_wdata = new_mark;
        wall_we    = 1'b0;
        wall_waddr = start_cell;
        wall_wdata = wb_reg;
        ord_we     = 1'b0;
        ord_waddr  = cnt_reg[CW-1:0];
        ord_wdata  = nb_reg;
        unique case (op)
            gaps_pkg::OP_CLR_ALL:
            begin
                mark_we    = 1'b1;
                mark_waddr = clr_reg;
                mark_wdata = '0;
                wall_we    = 1'b1;
                wall_waddr = clr_reg;
                wall_wdata = 1'b0;
            end
            gaps_pkg::OP_CLR_MARK:
            begin
                mark_we    = 1'b1;
                mark_waddr = clr_reg;
                mark_wdata = '0;
            end
            gaps_pkg::OP_WALL_WR:
            begin
                wall_we = 1'b1;
            end
            gaps_pkg::OP_START:
            begin
                mark_we         = 1'b1;
                mark_waddr      = start_cell;
                mark_wdata      = '0;
                mark_wdata.open = 1'b1;
                ord_we          = 1'b1;
                ord_waddr       = '0;
                ord_wdata       = start_cell;
            end
            gaps_pkg::OP_SHIFT:
            begin
                ord_we    = 1'b1;
                ord_waddr = k_reg;
                ord_wdata = ord_rd_reg;
            end
            gaps_pkg::OP_CLOSE:
            begin
                mark_we           = 1'b1;
                mark_waddr        = best_cell_reg;
                mark_wdata        = best_mark_reg;
                mark_wdata.closed = 1'b1;
            end
            gaps_pkg::OP_NB_EVAL, gaps_pkg::OP_H_WAIT:
            begin
                if (do_append)
                begin
                    mark_we = 1'b1;
                    ord_we  = !cnt_reg[NW-1];
                end
                else if ((op == gaps_pkg::OP_NB_EVAL) && nb_better)
                begin
                    mark_we           = 1'b1;
                    mark_wdata        = mark_rd_reg;
                    mark_wdata.g      = tc;
                    mark_wdata.pdir   = gaps_pkg::back_dir(dir_reg[2:0]);
                    mark_wdata.parent = 1'b1;
                end
            end
            gaps_pkg::OP_PATH:
            begin
                mark_we         = 1'b1;
                mark_waddr      = pc_reg;
                mark_wdata      = mark_rd_reg;
                mark_wdata.path = 1'b1;
            end
            default:
            begin
                mark_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        mark_rd_reg <= mark_mem[mark_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wall_we)
        begin
            wall_mem[wall_waddr] <= wall_wdata;
        end
        wall_rd_reg <= wall_mem[mark_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ord_we)
        begin
            ord_mem[ord_waddr] <= ord_wdata;
        end
        ord_rd_reg <= ord_mem[ord_raddr];
    end

    // Configuration registers; the user must make writes only while the engine is idle, the block does not enforce it.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hmode_reg <= 2'd0;
            diag_reg  <= 1'b1;
            gw_reg    <= 7'd64;
            gh_reg    <= 7'd64;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                gaps_pkg::CFG_HMODE:  hmode_reg <= cfg_data[1:0];
                gaps_pkg::CFG_DIAG:   diag_reg  <= cfg_data[0];
                gaps_pkg::CFG_WIDTH:  gw_reg    <= cfg_data;
                gaps_pkg::CFG_HEIGHT: gh_reg    <= cfg_data;
                default:              gw_reg    <= gw_reg;
            endcase
        end
    end

    // Control counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            cnt_reg       <= '0;
            k_reg         <= '0;
            dir_reg       <= '0;
            steps_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if ((op == gaps_pkg::OP_CLR_ALL) || (op == gaps_pkg::OP_CLR_MARK))
            begin
                clr_reg <= clr_reg + CW'(1);
            end

            case (op)
                gaps_pkg::OP_CLR_MARK:  cnt_reg <= '0;
                gaps_pkg::OP_START:     cnt_reg <= NW'(1);
                gaps_pkg::OP_PICK:
                begin
                    if (!(bk_p1 < cnt_reg))
                    begin
                        cnt_reg <= cnt_reg - NW'(1);
                    end
                end
                gaps_pkg::OP_SHIFT:
                begin
                    if (!(k_p2 < cnt_reg))
                    begin
                        cnt_reg <= cnt_reg - NW'(1);
                    end
                end
                default:
                begin
                    if (do_append && !cnt_reg[NW-1])
                    begin
                        cnt_reg <= cnt_reg + NW'(1);
                    end
                end
            endcase

            case (op)
                gaps_pkg::OP_SCAN_INIT: k_reg <= '0;
                gaps_pkg::OP_SCAN_B:    k_reg <= k_p1[CW-1:0];
                gaps_pkg::OP_PICK:      k_reg <= best_k_reg;
                gaps_pkg::OP_SHIFT:     k_reg <= k_p1[CW-1:0];
                default:                k_reg <= k_reg;
            endcase

            case (op)
                gaps_pkg::OP_CLOSE:   dir_reg <= '0;
                gaps_pkg::OP_NB:
                begin
                    if (!nb_inb)
                    begin
                        dir_reg <= dir_reg + 4'd1;
                    end
                end
                gaps_pkg::OP_NB_EVAL:
                begin
                    if (!need_sqrt)
                    begin
                        dir_reg <= dir_reg + 4'd1;
                    end
                end
                gaps_pkg::OP_H_WAIT:
                begin
                    if (sq_done)
                    begin
                        dir_reg <= dir_reg + 4'd1;
                    end
                end
                default: dir_reg <= dir_reg;
            endcase

            case (op)
                gaps_pkg::OP_PATH_INIT: steps_reg <= '0;
                gaps_pkg::OP_PATH:      steps_reg <= steps_reg + CW'(1);
                default:                steps_reg <= steps_reg;
            endcase

            if (op == gaps_pkg::OP_PUSH)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        case (op)
            gaps_pkg::OP_LATCH:
            begin
                cmd_reg <= cmd;
                x_reg   <= cell_x;
                y_reg   <= cell_y;
                wb_reg  <= wall_bit;
                gx_reg  <= goal_x;
                gy_reg  <= goal_y;
            end
            gaps_pkg::OP_SCAN_A:
            begin
                cand_reg <= ord_rd_reg;
            end
            gaps_pkg::OP_SCAN_B:
            begin
                // Ties go to the entry latest in open order.
                if ((k_reg == '0) || (scan_f <= best_f_reg))
                begin
                    best_f_reg    <= scan_f;
                    best_k_reg    <= k_reg;
                    best_cell_reg <= cand_reg;
                    best_mark_reg <= mark_rd_reg;
                end
            end
            gaps_pkg::OP_NB:
            begin
                nb_reg <= nb_cell;
            end
            gaps_pkg::OP_PATH_INIT:
            begin
                pc_reg <= best_cell_reg;
            end
            gaps_pkg::OP_PATH:
            begin
                pc_reg <= par_cell;
            end
            default:
            begin
                pc_reg <= pc_reg;
            end
        endcase

        case (op)
            gaps_pkg::OP_WALL_WR, gaps_pkg::OP_FAIL_RES:
            begin
                pend_found_reg <= 1'b0;
                pend_cost_reg  <= 16'd0;
                pend_wall_reg  <= 1'b0;
                pend_path_reg  <= 1'b0;
                pend_pdir_reg  <= 3'd0;
            end
            gaps_pkg::OP_RD_TAKE:
            begin
                pend_found_reg <= 1'b0;
                pend_cost_reg  <= mark_rd_reg.g;
                pend_wall_reg  <= wall_rd_reg;
                pend_path_reg  <= mark_rd_reg.path;
                pend_pdir_reg  <= mark_rd_reg.parent ? mark_rd_reg.pdir : 3'd0;
            end
            gaps_pkg::OP_PATH:
            begin
                pend_found_reg <= 1'b1;
                pend_cost_reg  <= best_mark_reg.g;
                pend_wall_reg  <= 1'b0;
                pend_path_reg  <= 1'b0;
                pend_pdir_reg  <= 3'd0;
            end
            gaps_pkg::OP_PUSH:
            begin
                out_found_reg <= pend_found_reg;
                out_cost_reg  <= pend_cost_reg;
                out_wall_reg  <= pend_wall_reg;
                out_path_reg  <= pend_path_reg;
                out_pdir_reg  <= pend_pdir_reg;
            end
            default:
            begin
                out_found_reg <= out_found_reg;
            end
        endcase
    end

    assign out_valid  = res_valid_reg;
    assign found      = out_found_reg;
    assign cost       = out_cost_reg;
    assign is_wall    = out_wall_reg;
    assign on_path    = out_path_reg;
    assign parent_dir = out_pdir_reg;

    // Status toward the controller.
    always_comb
    begin
        status            = '0;
        status.clr_last   = (clr_reg == '1);
        status.cmd        = cmd_reg;
        status.off_grid   = ({1'b0, x_reg} >= gw_reg) || ({1'b0, y_reg} >= gh_reg)
                            || ({1'b0, gx_reg} >= gw_reg) || ({1'b0, gy_reg} >= gh_reg);
        status.cnt_zero   = (cnt_reg == '0);
        status.scan_last  = (k_p1 == cnt_reg);
        status.pick_goal  = (best_cell_reg == goal_cell);
        status.pick_more  = (bk_p1 < cnt_reg);
        status.shift_more = (k_p2 < cnt_reg);
        status.nb_end     = (dir_reg == (diag_reg ? 4'd8 : 4'd4));
        status.nb_inb     = nb_inb;
        status.need_sqrt  = need_sqrt;
        status.sq_done    = sq_done;
        status.path_stop  = !mark_rd_reg.parent || path_off || (steps_reg == '1);
        status.slot_free  = !res_valid_reg || out_ready;
    end

    `GAPS_ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= NW'(gaps_pkg::NCELLS), "open count overflow")
    `GAPS_ASSERT_NEXT(a_push_valid, op == gaps_pkg::OP_PUSH, res_valid_reg, "result lost")
    `GAPS_ASSERT_ALWAYS(a_sq_mode, !sq_done || (hmode_reg == gaps_pkg::HMODE_EUCLID),
        "root finished outside euclidean mode")

endmodule

`default_nettype wire

// ===== design/gaps_ctrl.sv =====
// Controller of the grid A* engine: sequences clearing, wall writes, cell reads, open-list scan,
// expansion and path marking. Depends on gaps_pkg and the macro header.
`default_nettype none
`include "grid_astar_path_search_top_macros.svh"

module gaps_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire gaps_pkg::status_t  status,
    output gaps_pkg::ctrl_t         ctrl
);

    gaps_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gaps_pkg::ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gaps_pkg::ST_INIT:
                if (status.clr_last) state_next = gaps_pkg::ST_IDLE;
            gaps_pkg::ST_IDLE:
                if (in_valid) state_next = gaps_pkg::ST_DISPATCH;
            gaps_pkg::ST_DISPATCH:
            begin
                unique case (status.cmd)
                    gaps_pkg::CMD_WRITE:  state_next = gaps_pkg::ST_WRITE;
                    gaps_pkg::CMD_SEARCH: state_next = gaps_pkg::ST_CLR;
                    gaps_pkg::CMD_READ:   state_next = gaps_pkg::ST_RD_ISSUE;
                    default:              state_next = gaps_pkg::ST_NULL;
                endcase
            end
            gaps_pkg::ST_WRITE, gaps_pkg::ST_NULL, gaps_pkg::ST_RD_TAKE:
                state_next = gaps_pkg::ST_DONE;
            gaps_pkg::ST_RD_ISSUE:
                state_next = gaps_pkg::ST_RD_TAKE;
            gaps_pkg::ST_CLR:
                if (status.clr_last) state_next = gaps_pkg::ST_START;
            gaps_pkg::ST_START:
                state_next = status.off_grid ? gaps_pkg::ST_DONE : gaps_pkg::ST_SEL;
            gaps_pkg::ST_SEL:
                state_next = status.cnt_zero ? gaps_pkg::ST_DONE : gaps_pkg::ST_SCAN_A;
            gaps_pkg::ST_SCAN_A:
                state_next = gaps_pkg::ST_SCAN_B;
            gaps_pkg::ST_SCAN_B:
                state_next = status.scan_last ? gaps_pkg::ST_PICK : gaps_pkg::ST_SCAN_A;
            gaps_pkg::ST_PICK:
            begin
                if (status.pick_goal)
                    state_next = gaps_pkg::ST_PATH;
                else if (status.pick_more)
                    state_next = gaps_pkg::ST_SHIFT;
                else
                    state_next = gaps_pkg::ST_CLOSE;
            end
            gaps_pkg::ST_SHIFT:
                if (!status.shift_more) state_next = gaps_pkg::ST_CLOSE;
            gaps_pkg::ST_CLOSE:
                state_next = gaps_pkg::ST_NB;
            gaps_pkg::ST_NB:
            begin
                if (status.nb_end)
                    state_next = gaps_pkg::ST_SEL;
                else if (status.nb_inb)
                    state_next = gaps_pkg::ST_NB_EVAL;
            end
            gaps_pkg::ST_NB_EVAL:
                state_next = status.need_sqrt ? gaps_pkg::ST_H_WAIT : gaps_pkg::ST_NB;
            gaps_pkg::ST_H_WAIT:
                if (status.sq_done) state_next = gaps_pkg::ST_NB;
            gaps_pkg::ST_PATH:
                if (status.path_stop) state_next = gaps_pkg::ST_DONE;
            gaps_pkg::ST_DONE:
                if (status.slot_free) state_next = gaps_pkg::ST_IDLE;
            default:
                state_next = gaps_pkg::ST_INIT;
        endcase
    end

    always_comb
    begin
        ctrl.op  = gaps_pkg::OP_NOP;
        in_ready = 1'b0;
        unique case (state_reg)
            gaps_pkg::ST_INIT:     ctrl.op = gaps_pkg::OP_CLR_ALL;
            gaps_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) ctrl.op = gaps_pkg::OP_LATCH;
            end
            gaps_pkg::ST_DISPATCH: ctrl.op = gaps_pkg::OP_NOP;
            gaps_pkg::ST_WRITE:    ctrl.op = gaps_pkg::OP_WALL_WR;
            gaps_pkg::ST_NULL:     ctrl.op = gaps_pkg::OP_FAIL_RES;
            gaps_pkg::ST_RD_ISSUE: ctrl.op = gaps_pkg::OP_RD_ISSUE;
            gaps_pkg::ST_RD_TAKE:  ctrl.op = gaps_pkg::OP_RD_TAKE;
            gaps_pkg::ST_CLR:      ctrl.op = gaps_pkg::OP_CLR_MARK;
            gaps_pkg::ST_START:
                ctrl.op = status.off_grid ? gaps_pkg::OP_FAIL_RES : gaps_pkg::OP_START;
            gaps_pkg::ST_SEL:
                ctrl.op = status.cnt_zero ? gaps_pkg::OP_FAIL_RES : gaps_pkg::OP_SCAN_INIT;
            gaps_pkg::ST_SCAN_A:   ctrl.op = gaps_pkg::OP_SCAN_A;
            gaps_pkg::ST_SCAN_B:   ctrl.op = gaps_pkg::OP_SCAN_B;
            gaps_pkg::ST_PICK:
                ctrl.op = status.pick_goal ? gaps_pkg::OP_PATH_INIT : gaps_pkg::OP_PICK;
            gaps_pkg::ST_SHIFT:    ctrl.op = gaps_pkg::OP_SHIFT;
            gaps_pkg::ST_CLOSE:    ctrl.op = gaps_pkg::OP_CLOSE;
            gaps_pkg::ST_NB:
                ctrl.op = status.nb_end ? gaps_pkg::OP_NOP : gaps_pkg::OP_NB;
            gaps_pkg::ST_NB_EVAL:  ctrl.op = gaps_pkg::OP_NB_EVAL;
            gaps_pkg::ST_H_WAIT:   ctrl.op = gaps_pkg::OP_H_WAIT;
            gaps_pkg::ST_PATH:     ctrl.op = gaps_pkg::OP_PATH;
            gaps_pkg::ST_DONE:
                if (status.slot_free) ctrl.op = gaps_pkg::OP_PUSH;
            default:               ctrl.op = gaps_pkg::OP_NOP;
        endcase
    end

    `GAPS_ASSERT_NEXT(a_leave_idle, in_valid && in_ready, state_reg == gaps_pkg::ST_DISPATCH,
        "accepted request not dispatched")

endmodule

`default_nettype wire

// ===== design/grid_astar_path_search_top.sv =====
// Grid A* search engine, 64x64 cells; holds gaps_ctrl and gaps_datapath, uses gaps_pkg.
// Reset runs a clearing pass over the cell and wall stores; in_ready stays low until it ends.
// One request at a time: a write runs dispatch, write, push; a read dispatch, issue, take, push.
// A search clears the marks of every cell; each expansion scans the open list entry by entry,
// closes the list up over the picked entry, evaluates each on-grid neighbor (waiting on the
// root unit for a new one under the euclidean estimate); path marking walks the parent links.
`default_nettype none

module grid_astar_path_search_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  cmd,
    input  wire logic [5:0]  cell_x,
    input  wire logic [5:0]  cell_y,
    input  wire logic        wall_bit,
    input  wire logic [5:0]  goal_x,
    input  wire logic [5:0]  goal_y,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             found,
    output logic [15:0]      cost,
    output logic             is_wall,
    output logic             on_path,
    output logic [2:0]       parent_dir,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [6:0]  cfg_data
);

    gaps_pkg::ctrl_t   ctrl;
    gaps_pkg::status_t status;

    gaps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .ctrl     (ctrl)
    );

    gaps_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .status     (status),
        .cmd        (cmd),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .wall_bit   (wall_bit),
        .goal_x     (goal_x),
        .goal_y     (goal_y),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .found      (found),
        .cost       (cost),
        .is_wall    (is_wall),
        .on_path    (on_path),
        .parent_dir (parent_dir),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

endmodule

`default_nettype wire
